// ===== design/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted while in reset.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, muted while in reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/ple_pkg.sv =====
`default_nettype none
package ple_pkg;

   localparam int CAPACITY = 16;
   localparam int ELEM_W   = 32;
   localparam int POS_W    = 5;
   localparam int OCC_W    = 5;
   localparam int OP_W     = 3;
   localparam int STAT_W   = 2;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [OP_W-1:0] {
      OP_ADD_FRONT = 3'd0,
      OP_ADD_REAR  = 3'd1,
      OP_DEL_FRONT = 3'd2,
      OP_DEL_REAR  = 3'd3,
      OP_DEL_AT    = 3'd4,
      OP_INS_AT    = 3'd5
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_RANGE     = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic load;    // capture the incoming request
      logic commit;  // apply it to the list and load the result register
   } cmd_type;

endpackage
`default_nettype wire

// ===== design/ple_ctrl.sv =====
`default_nettype none
module ple_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire logic            rsp_tready,
   output ple_pkg::cmd_type     cmd
);
   import ple_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   assign cmd.load   = req_tvalid && req_tready;
   assign cmd.commit = (state_ff == S_EXEC) && out_free;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (cmd.load) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // wait here while the previous result is still unclaimed
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/ple_datapath.sv =====
`default_nettype none
module ple_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire ple_pkg::cmd_type                  cmd,
   input  wire logic [ple_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic [ple_pkg::RSP_DATA_W-1:0]         rsp_tdata
);
   import ple_pkg::*;

   logic [OP_W-1:0]   op_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [ELEM_W-1:0] val_ff;
   logic [CNT_W-1:0]  occ_ff, occ_in;
   logic [ELEM_W-1:0] cells_ff [CAPACITY];
   logic [ELEM_W-1:0] cells_in [CAPACITY];
   logic [RSP_DATA_W-1:0] rsp_ff;

   logic [CMP_W-1:0]  pos_w, occ_w;
   logic              full, empty;
   logic              do_put, do_take;
   logic [IDX_W-1:0]  idx;
   status_type        status;
   logic [ELEM_W-1:0] removed;

   assign pos_w = CMP_W'(pos_ff);
   assign occ_w = CMP_W'(occ_ff);
   assign full  = (occ_ff == CNT_W'(CAPACITY));
   assign empty = (occ_ff == '0);

   always_comb begin
      do_put  = 1'b0;
      do_take = 1'b0;
      status  = ST_OK;
      idx     = '0;
      case (op_ff)
         OP_ADD_FRONT: begin
            if (full) status = ST_FULL;
            else do_put = 1'b1;
         end
         OP_ADD_REAR: begin
            idx = IDX_W'(occ_ff);
            if (full) status = ST_FULL;
            else do_put = 1'b1;
         end
         OP_DEL_FRONT: begin
            if (empty) status = ST_UNDERFLOW;
            else do_take = 1'b1;
         end
         OP_DEL_REAR: begin
            idx = IDX_W'(occ_ff - CNT_W'(1));
            if (empty) status = ST_UNDERFLOW;
            else do_take = 1'b1;
         end
         OP_DEL_AT: begin
            idx = IDX_W'(pos_w - CMP_W'(1));
            if (pos_w == '0 || pos_w > occ_w) status = ST_RANGE;
            else do_take = 1'b1;
         end
         OP_INS_AT: begin
            idx = IDX_W'(pos_w - CMP_W'(1));
            // range test first, then the empty-list rule, then capacity
            if (pos_w == '0 || pos_w > occ_w + CMP_W'(1)) status = ST_RANGE;
            else if (empty) status = ST_UNDERFLOW;
            else if (full) status = ST_FULL;
            else do_put = 1'b1;
         end
         default: ;
      endcase
   end

   assign removed = do_take ? cells_ff[idx] : '0;

   always_comb begin
      occ_in = occ_ff;
      if (do_put) occ_in = occ_ff + CNT_W'(1);
      else if (do_take) occ_in = occ_ff - CNT_W'(1);
   end

   // each cell holds, takes the new value, takes its left neighbor (open a gap) or its right one (close a gap)
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [ELEM_W-1:0] prev_w, next_w;
      if (g == 0) begin : g_first
         assign prev_w = cells_ff[g];
      end else begin : g_mid
         assign prev_w = cells_ff[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign next_w = cells_ff[g];
      end else begin : g_body
         assign next_w = cells_ff[g+1];
      end
      always_comb begin
         cells_in[g] = cells_ff[g];
         if (do_put) begin
            if (IDX_W'(g) == idx) cells_in[g] = val_ff;
            else if (IDX_W'(g) > idx) cells_in[g] = prev_w;
         end else if (do_take) begin
            if (IDX_W'(g) >= idx) cells_in[g] = next_w;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_tdata[OP_W-1:0];
         pos_ff <= req_tdata[OP_W +: POS_W];
         val_ff <= req_tdata[OP_W+POS_W +: ELEM_W];
      end
      if (cmd.commit) begin
         for (int i = 0; i < CAPACITY; i++) begin
            cells_ff[i] <= cells_in[i];
         end
         rsp_ff <= {occ_in == '0, OCC_W'(occ_in), removed, status};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else if (cmd.commit) begin
         occ_ff <= occ_in;
      end
   end

   assign rsp_tdata = rsp_ff;

endmodule
`default_nettype wire

// ===== design/positional_list_engine.sv =====
`default_nettype none
// Ordered list of up to CAPACITY signed 32-bit elements held in a shift-capable
// register array. Each request carries an op (add front/rear, delete front/rear,
// delete at or insert at a 1-based position) and returns exactly one response
// with status, the removed element (zero unless a delete succeeds), the count
// afterward and an empty flag. A request is captured first; then each cell
// holds, moves one place or takes the new value and the result register loads.
// The response waits in that register, so the next request is taken meanwhile; a
// stalled response holds the execute step until it drains.
`include "assert_macros.svh"
module positional_list_engine (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [2:0] op, [7:3] position, [39:8] value
   input  wire logic [ple_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [1:0] status, [33:2] removed_value, [38:34] occupancy_out, [39] is_empty
   output logic [ple_pkg::RSP_DATA_W-1:0]         rsp_tdata
);
   import ple_pkg::*;

   cmd_type cmd;

   ple_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   ple_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)
   `ASSERT_SAME(a_full_count, clock, reset,
      rsp_tvalid && (rsp_tdata[STAT_W-1:0] == ST_FULL),
      rsp_tdata[RSP_DATA_W-2 -: OCC_W] == OCC_W'(CAPACITY))
   `ASSERT_SAME(a_rsp_after_exec, clock, reset, $rose(rsp_tvalid), $past(!req_tready))

endmodule
`default_nettype wire

// ===== test/ple_list_checker.sv =====
`default_nettype none
module ple_list_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   input  wire logic                           req_tready,
   input  wire logic [ple_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   input  wire logic [ple_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                                  error_count,
   output int                                  pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import ple_pkg::*;

   typedef struct {
      status_type         status;
      logic [ELEM_W-1:0]  removed;
      logic [OCC_W-1:0]   count;
      logic               empty;
   } list_result_type;

   logic [ELEM_W-1:0] shadow_cells [CAPACITY];
   int                shadow_count;
   list_result_type   awaited_results [$];

   // open a gap at index k and place v there
   function automatic void shadow_insert(input int k, input logic [ELEM_W-1:0] v);
      for (int i = shadow_count; i > k; i--)
         shadow_cells[i] = shadow_cells[i-1];
      shadow_cells[k] = v;
      shadow_count++;
   endfunction

   function automatic logic [ELEM_W-1:0] shadow_remove(input int k);
      logic [ELEM_W-1:0] v;
      v = shadow_cells[k];
      for (int i = k; i + 1 < shadow_count; i++)
         shadow_cells[i] = shadow_cells[i+1];
      shadow_count--;
      return v;
   endfunction

   function automatic list_result_type predict_list_op(input logic [REQ_DATA_W-1:0] word);
      list_result_type   res;
      logic [OP_W-1:0]   code;
      int                pos;
      logic [ELEM_W-1:0] val;
      code = word[2:0];
      pos = int'(word[7:3]);
      val = word[39:8];
      res.status = ST_OK;
      res.removed = '0;
      case (code)
         OP_ADD_FRONT: begin
            if (shadow_count >= CAPACITY) res.status = ST_FULL;
            else shadow_insert(0, val);
         end
         OP_ADD_REAR: begin
            if (shadow_count >= CAPACITY) res.status = ST_FULL;
            else shadow_insert(shadow_count, val);
         end
         OP_DEL_FRONT: begin
            if (shadow_count == 0) res.status = ST_UNDERFLOW;
            else res.removed = shadow_remove(0);
         end
         OP_DEL_REAR: begin
            if (shadow_count == 0) res.status = ST_UNDERFLOW;
            else res.removed = shadow_remove(shadow_count - 1);
         end
         OP_DEL_AT: begin
            if (pos < 1 || pos > shadow_count) res.status = ST_RANGE;
            else res.removed = shadow_remove(pos - 1);
         end
         OP_INS_AT: begin
            // range test wins over the empty-list rule
            if (pos < 1 || pos > shadow_count + 1) res.status = ST_RANGE;
            else if (shadow_count == 0) res.status = ST_UNDERFLOW;
            else if (shadow_count >= CAPACITY) res.status = ST_FULL;
            else shadow_insert(pos - 1, val);
         end
         default: ;
      endcase
      res.count = OCC_W'(shadow_count);
      res.empty = (shadow_count == 0);
      return res;
   endfunction

   always @(posedge clock) begin
      list_result_type want;
      if (reset) begin
         shadow_count = 0;
         awaited_results.delete();
      end else begin
         if (req_tvalid && req_tready)
            awaited_results.push_back(predict_list_op(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               $error("response with no request outstanding: %h", rsp_tdata);
               error_count++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_tdata[1:0] !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_tdata[1:0]);
                  error_count++;
               end
               if (rsp_tdata[33:2] !== want.removed) begin
                  $error("removed_value: expected %h, actual %h",
                         want.removed, rsp_tdata[33:2]);
                  error_count++;
               end
               if (rsp_tdata[38:34] !== want.count) begin
                  $error("occupancy_out: expected %0d, actual %0d",
                         want.count, rsp_tdata[38:34]);
                  error_count++;
               end
               if (rsp_tdata[39] !== want.empty) begin
                  $error("is_empty: expected %0d, actual %0d", want.empty, rsp_tdata[39]);
                  error_count++;
               end
            end
         end
      end
      pending = awaited_results.size();
   end

   initial begin
      error_count = 0;
      pending = 0;
      shadow_count = 0;
   end

endmodule
`default_nettype wire

// ===== test/tb_positional_list_engine.sv =====
`default_nettype none
module tb_positional_list_engine;
   timeunit 1ns;
   timeprecision 1ps;
   import ple_pkg::*;

   // codes the block must ignore
   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
   localparam int RANDOM_REQUESTS = 1200;
   localparam int PHASE_LEN       = 40;
   localparam int HOLD_CYCLES     = 60;
   localparam int STALL_LIMIT     = 2000;
   localparam int DRAIN_CYCLES    = 10;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   int                    error_count;
   int                    pending;
   int                    quiet_cycles = 0;
   logic                  steady = 1'b0;
   logic                  hold_off_request = 1'b0;

   positional_list_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ple_list_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .error_count (error_count),
      .pending     (pending)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   function automatic logic [ELEM_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [POS_W-1:0] pick_position();
      if ($urandom_range(0, 99) < 85) return POS_W'($urandom_range(1, CAPACITY + 1));
      return POS_W'($urandom_range(0, 31));
   endfunction

   task automatic send_request(input logic [OP_W-1:0] code, input logic [POS_W-1:0] pos,
                               input logic [ELEM_W-1:0] val);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 14) begin
         req_tvalid = 1'b0;
         req_tdata = {8'($urandom), 32'($urandom)};
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {val, pos, code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // receiver: random backpressure, plus a long hold-off on demand
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready = steady || ($urandom_range(0, 99) >= 14);
      end
   end

   initial begin
      int               counted;
      int               r;
      logic             filling;
      logic [OP_W-1:0]  code;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty-list corner cases and the ignored codes
      send_request(OP_DEL_FRONT, 5'd0, 32'h0);
      send_request(OP_DEL_REAR, 5'd0, 32'h0);
      send_request(OP_DEL_AT, 5'd1, 32'h0);
      send_request(OP_INS_AT, 5'd1, 32'h1234_5678);
      send_request(OP_INS_AT, 5'd0, 32'h1234_5678);
      send_request(OP_SPARE_A, 5'd31, 32'hffff_ffff);
      send_request(OP_SPARE_B, 5'd31, 32'hffff_ffff);
      // fill to capacity through all three add paths
      for (int i = 0; i < CAPACITY; i++) begin
         case (i % 3)
            0: code = OP_ADD_FRONT;
            1: code = OP_ADD_REAR;
            default: code = OP_INS_AT;
         endcase
         send_request(code, POS_W'(i / 2 + 1),
                      (i == 0) ? 32'h8000_0000 : (i == 1) ? 32'h7fff_ffff : $urandom);
      end
      send_request(OP_ADD_REAR, 5'd0, 32'h0);
      send_request(OP_INS_AT, 5'd3, 32'h0);
      send_request(OP_DEL_AT, 5'd17, 32'h0);
      send_request(OP_DEL_AT, 5'd16, 32'h0);
      send_request(OP_DEL_AT, 5'd0, 32'h0);
      send_request(OP_INS_AT, 5'd17, 32'h0);

      // random part: alternating fill-biased and drain-biased phases
      counted = 0;
      while (counted < RANDOM_REQUESTS) begin
         steady = (counted >= 500 && counted < 700);
         if (counted == 300 || counted == 900) hold_off_request = 1'b1;
         filling = ((counted / PHASE_LEN) % 2) == 0;
         r = $urandom_range(0, 99);
         if (filling) begin
            if (r < 25) code = OP_ADD_FRONT;
            else if (r < 50) code = OP_ADD_REAR;
            else if (r < 70) code = OP_INS_AT;
            else if (r < 80) code = OP_DEL_FRONT;
            else if (r < 88) code = OP_DEL_REAR;
            else if (r < 98) code = OP_DEL_AT;
            else code = (r == 98) ? OP_SPARE_A : OP_SPARE_B;
         end else begin
            if (r < 25) code = OP_DEL_FRONT;
            else if (r < 50) code = OP_DEL_REAR;
            else if (r < 70) code = OP_DEL_AT;
            else if (r < 80) code = OP_ADD_FRONT;
            else if (r < 88) code = OP_ADD_REAR;
            else if (r < 98) code = OP_INS_AT;
            else code = (r == 98) ? OP_SPARE_A : OP_SPARE_B;
         end
         send_request(code, pick_position(), pick_value());
         if (code != OP_SPARE_A && code != OP_SPARE_B) counted++;
      end
      @(negedge clock);
      req_tvalid = 1'b0;
      steady = 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+design
design/ple_pkg.sv
design/ple_ctrl.sv
design/ple_datapath.sv
design/positional_list_engine.sv
test/ple_list_checker.sv
test/tb_positional_list_engine.sv
